>>> rtl/fxa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fxa_pkg: shared types and constants for the Q24.8 fixed-point ALU
// Opcodes, default fraction width and the sideband word that rides the
// divider chain next to the quotient.
// ----------------------------------------------------------------------------
package fxa_pkg;

   localparam int FRAC_BITS_DEF = 8;
   localparam int WORD_W        = 32;

   typedef enum logic [3:0] {
      CMD_ADD      = 4'd0,
      CMD_SUB      = 4'd1,
      CMD_MUL      = 4'd2,
      CMD_DIV      = 4'd3,
      CMD_GT       = 4'd4,
      CMD_LT       = 4'd5,
      CMD_GE       = 4'd6,
      CMD_LE       = 4'd7,
      CMD_EQ       = 4'd8,
      CMD_NE       = 4'd9,
      CMD_MIN      = 4'd10,
      CMD_MAX      = 4'd11,
      CMD_INC      = 4'd12,
      CMD_DEC      = 4'd13,
      CMD_FROM_INT = 4'd14,
      CMD_TO_INT   = 4'd15
   } cmd_type;

   // Per-word control and early result, carried alongside the divide cells.
   typedef struct packed {
      logic                     valid;
      logic                     is_div;   // quotient replaces res at the end
      logic                     is_mul;   // product replaces res at chain entry
      logic                     neg;      // quotient sign
      logic                     dz;       // zero divisor seen
      logic                     cmp;      // comparison outcome
      logic signed [WORD_W-1:0] res;      // result of the ops computed at decode
   } fxa_side_type;

endpackage
`default_nettype wire

>>> rtl/fxa_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fxa_front: operand decode stage
// Registers the results of the simple ops, the full signed product and the
// unsigned dividend and divisor for the division chain.
// ----------------------------------------------------------------------------
module fxa_front
   import fxa_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int DW = WORD_W + FRAC_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic [3:0]                 cmd,
   input  wire logic signed [WORD_W-1:0]   a,
   input  wire logic signed [WORD_W-1:0]   b,
   output fxa_side_type                    side_ff,
   output logic signed [2*WORD_W-1:0]      prod_ff,
   output logic [DW-1:0]                   dvd_ff,
   output logic [WORD_W-1:0]               dvs_ff
);

   fxa_side_type              side_in;
   logic [WORD_W-1:0]         mag_a;
   logic [WORD_W-1:0]         mag_b;

   // magnitudes; the most negative value maps to 2^31 unsigned
   assign mag_a = a[WORD_W-1] ? WORD_W'(-a) : WORD_W'(a);
   assign mag_b = b[WORD_W-1] ? WORD_W'(-b) : WORD_W'(b);

   always_comb begin
      side_in        = '0;
      side_in.valid  = in_valid;
      side_in.neg    = a[WORD_W-1] ^ b[WORD_W-1];
      case (cmd_type'(cmd))
         CMD_ADD:      side_in.res = a + b;
         CMD_SUB:      side_in.res = a - b;
         CMD_MUL:      side_in.is_mul = 1'b1;
         CMD_DIV: begin
            side_in.is_div = (b != '0);
            side_in.dz     = (b == '0);
         end
         CMD_GT:       side_in.cmp = (a > b);
         CMD_LT:       side_in.cmp = (a < b);
         CMD_GE:       side_in.cmp = (a >= b);
         CMD_LE:       side_in.cmp = (a <= b);
         CMD_EQ:       side_in.cmp = (a == b);
         CMD_NE:       side_in.cmp = (a != b);
         CMD_MIN:      side_in.res = (a < b) ? a : b;
         CMD_MAX:      side_in.res = (a > b) ? a : b;
         CMD_INC:      side_in.res = a + WORD_W'(1);
         CMD_DEC:      side_in.res = a - WORD_W'(1);
         CMD_FROM_INT: side_in.res = a <<< FRAC_BITS;
         CMD_TO_INT:   side_in.res = a >>> FRAC_BITS;
         default:      side_in.res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
      end else begin
         side_ff <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= (2*WORD_W)'(a) * (2*WORD_W)'(b);
      dvd_ff  <= {mag_a, {FRAC_BITS{1'b0}}};
      dvs_ff  <= mag_b;
   end

endmodule
`default_nettype wire

>>> rtl/fxa_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fxa_div_cell: one restoring-division cell
// Retires one quotient bit per cell and hands remainder, shifting
// dividend/quotient, divisor and sideband to the next cell.
// ----------------------------------------------------------------------------
module fxa_div_cell
   import fxa_pkg::*;
#(
   parameter int DW = WORD_W + FRAC_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fxa_side_type      side_i,
   input  wire logic [WORD_W-1:0] rem_i,
   input  wire logic [DW-1:0]     dq_i,
   input  wire logic [WORD_W-1:0] dvs_i,
   output fxa_side_type           side_ff,
   output logic [WORD_W-1:0]      rem_ff,
   output logic [DW-1:0]          dq_ff,
   output logic [WORD_W-1:0]      dvs_ff
);

   logic [WORD_W:0]   trial;
   logic              qbit;
   logic [WORD_W-1:0] rem_in;
   logic [DW-1:0]     dq_in;

   // bring down the next dividend bit, try the subtract
   assign trial  = {rem_i, dq_i[DW-1]};
   assign qbit   = (trial >= {1'b0, dvs_i});
   assign rem_in = qbit ? WORD_W'(trial - {1'b0, dvs_i}) : trial[WORD_W-1:0];
   assign dq_in  = {dq_i[DW-2:0], qbit};

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
      end else begin
         side_ff <= side_i;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      dvs_ff <= dvs_i;
   end

endmodule
`default_nettype wire

>>> rtl/fixed_point_alu_q24_8_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8_unit: signed Q24.8 fixed-point ALU
// Fully pipelined ALU: one word in per cycle, one result word out per word,
// in order, after a fixed latency.
// ----------------------------------------------------------------------------
// A new word is taken on every clock where start is high; busy is always
// low, so start may be held high to stream one word per cycle. Every word
// passes through one decode/multiply stage, one divide cell per quotient
// bit (32 + FRAC_BITS of them), and the output register. All opcodes take
// that same path, so results leave in issue order. rsp_valid marks each
// result for exactly one cycle and the receiver must take it then; there
// is no back-pressure. Synchronous reset drops every word in flight.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8_unit
   import fxa_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [3:0]               req_cmd,
   input  wire logic signed [WORD_W-1:0] req_operand_a,
   input  wire logic signed [WORD_W-1:0] req_operand_b,
   output logic                          rsp_valid,
   output logic signed [WORD_W-1:0]      rsp_result,
   output logic                          rsp_compare_true,
   output logic                          rsp_divide_by_zero
);

   // dividend is |a| scaled by 2^FRAC_BITS; one cell per quotient bit
   localparam int DW = WORD_W + FRAC_BITS;

   fxa_side_type                front_side;
   logic signed [2*WORD_W-1:0]  prod;
   logic [DW-1:0]               dvd;
   logic [WORD_W-1:0]           dvs;

   fxa_side_type                side_w [0:DW];
   logic [WORD_W-1:0]           rem_w  [0:DW];
   logic [DW-1:0]               dq_w   [0:DW];
   logic [WORD_W-1:0]           dvs_w  [0:DW];

   fxa_side_type                last;
   logic [WORD_W-1:0]           quo;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_W-1:0]    rsp_result_ff, rsp_result_in;
   logic                        rsp_cmp_ff, rsp_cmp_in;
   logic                        rsp_dz_ff, rsp_dz_in;

   // no stall anywhere: a word can enter on every cycle
   assign busy = 1'b0;

   fxa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .cmd      (req_cmd),
      .a        (req_operand_a),
      .b        (req_operand_b),
      .side_ff  (front_side),
      .prod_ff  (prod),
      .dvd_ff   (dvd),
      .dvs_ff   (dvs)
   );

   // chain entry: multiply result is the product shifted down by FRAC_BITS,
   // wrapped to 32 bits
   always_comb begin
      side_w[0] = front_side;
      if (front_side.is_mul) begin
         side_w[0].res = prod[FRAC_BITS+WORD_W-1 -: WORD_W];
      end
   end
   assign rem_w[0] = '0;
   assign dq_w[0]  = dvd;
   assign dvs_w[0] = dvs;

   for (genvar i = 0; i < DW; i++) begin : g_cell
      fxa_div_cell #(.DW(DW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .side_i  (side_w[i]),
         .rem_i   (rem_w[i]),
         .dq_i    (dq_w[i]),
         .dvs_i   (dvs_w[i]),
         .side_ff (side_w[i+1]),
         .rem_ff  (rem_w[i+1]),
         .dq_ff   (dq_w[i+1]),
         .dvs_ff  (dvs_w[i+1])
      );
   end

   // chain exit: apply the quotient sign; truncation toward zero falls out
   // of dividing magnitudes, and keeping the low 32 bits wraps
   assign last = side_w[DW];
   assign quo  = dq_w[DW][WORD_W-1:0];

   always_comb begin
      rsp_valid_in  = last.valid;
      rsp_cmp_in    = last.cmp;
      rsp_dz_in     = last.dz;
      rsp_result_in = last.res;
      if (last.is_div) begin
         rsp_result_in = last.neg ? WORD_W'(-quo) : quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
      rsp_cmp_ff    <= rsp_cmp_in;
      rsp_dz_ff     <= rsp_dz_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result         = rsp_result_ff;
   assign rsp_compare_true   = rsp_cmp_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

endmodule
`default_nettype wire

>>> rtl/fxa_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fxa_checker: port-level checks for the fixed-point ALU
// Fixed latency, flag exclusivity and reset behavior, bound to the top level.
// ----------------------------------------------------------------------------
module fxa_checker
   import fxa_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int LAT = WORD_W + FRAC_BITS + 2
) (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     start,
   input wire logic                     busy,
   input wire logic                     rsp_valid,
   input wire logic signed [WORD_W-1:0] rsp_result,
   input wire logic                     rsp_compare_true,
   input wire logic                     rsp_divide_by_zero
);

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("accepted word did not return after fixed latency");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> (rsp_result == '0) && !rsp_compare_true)
      else $error("zero-divisor word carries a result or compare flag");

   a_cmp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_compare_true) |-> (rsp_result == '0))
      else $error("true comparison carries a nonzero result");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe after reset");

endmodule

bind fixed_point_alu_q24_8_unit fxa_checker #(.FRAC_BITS(FRAC_BITS)) u_fxa_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_result         (rsp_result),
   .rsp_compare_true   (rsp_compare_true),
   .rsp_divide_by_zero (rsp_divide_by_zero)
);
`default_nettype wire

>>> tb/tb_fixed_point_alu_q24_8_unit.sv
// ----------------------------------------------------------------------------
// tb_fixed_point_alu_q24_8_unit: self-checking bench for the Q24.8 ALU
// Drives command words through the start/busy handshake and predicts each
// result word with a local model of the ALU. Every rsp_valid word is checked
// field by field against the oldest prediction. A directed pass hits the wrap,
// rounding, zero-divisor and signed-compare corners, and a random pass streams
// about 1100 words with and without idle gaps.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu_q24_8_unit;
   import fxa_pkg::*;

   localparam int FRAC    = FRAC_BITS_DEF;
   // decode stage + one divide cell per quotient bit + output register
   localparam int LATENCY = WORD_W + FRAC + 2;
   localparam int N_RANDOM = 1100;

   // one predicted result word
   typedef struct packed {
      logic signed [WORD_W-1:0] result;
      logic                     compare_true;
      logic                     divide_by_zero;
   } alu_word_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   cmd_type                  req_cmd = CMD_ADD;
   logic signed [WORD_W-1:0] req_operand_a = '0;
   logic signed [WORD_W-1:0] req_operand_b = '0;
   logic                     rsp_valid;
   logic signed [WORD_W-1:0] rsp_result;
   logic                     rsp_compare_true;
   logic                     rsp_divide_by_zero;

   // predictions waiting for their result word, oldest first
   alu_word_type alu_answers_q[$];
   alu_word_type want;

   bit idle_enabled = 1'b1;  // off = back-to-back streaming
   int words_sent   = 0;
   int words_seen   = 0;
   int zero_divs    = 0;
   int fail_count   = 0;
   int op_hits[16];

   fixed_point_alu_q24_8_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_operand_a      (req_operand_a),
      .req_operand_b      (req_operand_b),
      .rsp_valid          (rsp_valid),
      .rsp_result         (rsp_result),
      .rsp_compare_true   (rsp_compare_true),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always #5 clock = ~clock;

   // Predict one result word. Add, sub, mul, div, inc and dec are done in 64
   // bits and wrapped to the 32-bit result field.
   function automatic alu_word_type alu_compute(cmd_type op, logic signed [WORD_W-1:0] a,
                                                logic signed [WORD_W-1:0] b);
      longint       sa;
      longint       sb;
      longint       wide;
      alu_word_type w;
      sa = a;
      sb = b;
      w  = '0;
      case (op)
         CMD_ADD: w.result = WORD_W'(sa + sb);
         CMD_SUB: w.result = WORD_W'(sa - sb);
         CMD_MUL: begin
            // full product, arithmetic shift floors toward minus infinity
            wide     = sa * sb;
            w.result = WORD_W'(wide >>> FRAC);
         end
         CMD_DIV: begin
            if (sb == 0) begin
               w.divide_by_zero = 1'b1;
            end else begin
               // exact scaled dividend; SV division truncates toward zero
               wide     = sa * (longint'(1) << FRAC);
               w.result = WORD_W'(wide / sb);
            end
         end
         CMD_GT:       w.compare_true = (sa >  sb);
         CMD_LT:       w.compare_true = (sa <  sb);
         CMD_GE:       w.compare_true = (sa >= sb);
         CMD_LE:       w.compare_true = (sa <= sb);
         CMD_EQ:       w.compare_true = (sa == sb);
         CMD_NE:       w.compare_true = (sa != sb);
         CMD_MIN:      w.result = (sa < sb) ? a : b;  // ties give b
         CMD_MAX:      w.result = (sa > sb) ? a : b;  // ties give b
         CMD_INC:      w.result = WORD_W'(sa + 1);
         CMD_DEC:      w.result = WORD_W'(sa - 1);
         CMD_FROM_INT: w.result = a << FRAC;
         default:      w.result = a >>> FRAC;         // to_int
      endcase
      return w;
   endfunction

   // Operand mix: extremes, zero, small raw values, whole numbers, full random.
   function automatic logic [WORD_W-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'($urandom_range(0, 1023)) - 32'd512;
         4: return (32'($urandom_range(0, 400)) - 32'd200) << FRAC;
         default: return $urandom;
      endcase
   endfunction

   // Send one command word. An optional idle gap comes first; start then
   // stays high after acceptance so back-to-back words never drop it.
   task automatic send_word(input cmd_type op, input logic [WORD_W-1:0] a,
                            input logic [WORD_W-1:0] b);
      int unsigned gap;
      gap = idle_enabled ? $urandom_range(0, 13) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_cmd       <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      alu_answers_q.push_back(alu_compute(op, a, b));
      op_hits[op]++;
      words_sent++;
   endtask

   // Wrap on add/sub/inc/dec and bits shifted out by from_int.
   task automatic test_wrap_and_step();
      send_word(CMD_ADD,      32'h7FFF_FFFF, 32'h0000_0001);
      send_word(CMD_SUB,      32'h8000_0000, 32'h0000_0001);
      send_word(CMD_INC,      32'h7FFF_FFFF, $urandom);
      send_word(CMD_DEC,      32'h8000_0000, $urandom);
      send_word(CMD_FROM_INT, 32'hFFFF_FFFF, $urandom);
   endtask

   // Multiply overflow and flooring, divide by zero, min / -1, truncation.
   task automatic test_mul_div_corners();
      send_word(CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_word(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
      send_word(CMD_MUL, 32'hFFFF_FFFF, 32'h0000_0001);   // -1 ulp * 1 ulp floors
      send_word(CMD_MUL, 32'h0000_0180, 32'hFFFF_FE00);   // 1.5 * -2
      send_word(CMD_DIV, 32'h0000_0100, 32'h0000_0000);   // zero divisor
      send_word(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);   // most negative / -ulp
      send_word(CMD_DIV, 32'hFFFF_FD00, 32'h0000_0200);   // -3 / 2 toward zero
      send_word(CMD_DIV, 32'h7FFF_FFFF, 32'h0000_0001);   // quotient wraps
   endtask

   // All six compares on equal operands, plus one signed-order check.
   task automatic test_compare_equal();
      send_word(CMD_GT, 32'h8000_0000, 32'h8000_0000);
      send_word(CMD_LT, 32'h8000_0000, 32'h8000_0000);
      send_word(CMD_GE, 32'h8000_0000, 32'h8000_0000);
      send_word(CMD_LE, 32'h8000_0000, 32'h8000_0000);
      send_word(CMD_EQ, 32'h8000_0000, 32'h8000_0000);
      send_word(CMD_NE, 32'h8000_0000, 32'h8000_0000);
      send_word(CMD_GT, 32'h7FFF_FFFF, 32'h8000_0000);
   endtask

   // Signed min/max across the extremes; to_int rounds toward minus infinity.
   task automatic test_min_max_to_int();
      send_word(CMD_MIN,    32'h8000_0000, 32'h7FFF_FFFF);
      send_word(CMD_MAX,    32'h8000_0000, 32'h7FFF_FFFF);
      send_word(CMD_TO_INT, 32'hFFFF_FF01, $urandom);
      send_word(CMD_TO_INT, 32'h7FFF_FFFF, $urandom);
   endtask

   // Random opcodes and operands. Idle gaps switch on and off in blocks so
   // long back-to-back stretches stream through the pipeline too. Some words
   // get equal operands (compare ties) or a zero divisor.
   task automatic test_random_mix();
      cmd_type           op;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i % 50 == 0) idle_enabled = ($urandom_range(0, 2) != 0);
         op = cmd_type'($urandom_range(0, 15));
         a  = pick_operand();
         b  = pick_operand();
         if ($urandom_range(0, 7) == 0) b = a;
         if (op == CMD_DIV && $urandom_range(0, 9) == 0) b = '0;
         send_word(op, a, b);
      end
      idle_enabled = 1'b1;
   endtask

   // Result checker: every strobed word must match the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         words_seen++;
         if (alu_answers_q.size() == 0) begin
            $error("unexpected result word: result %0d", rsp_result);
            fail_count++;
         end else begin
            want = alu_answers_q.pop_front();
            if (want.divide_by_zero) zero_divs++;
            if (rsp_result !== want.result) begin
               $error("rsp_result mismatch: expected %0d, actual %0d",
                      want.result, rsp_result);
               fail_count++;
            end
            if (rsp_compare_true !== want.compare_true) begin
               $error("rsp_compare_true mismatch: expected %0b, actual %0b",
                      want.compare_true, rsp_compare_true);
               fail_count++;
            end
            if (rsp_divide_by_zero !== want.divide_by_zero) begin
               $error("rsp_divide_by_zero mismatch: expected %0b, actual %0b",
                      want.divide_by_zero, rsp_divide_by_zero);
               fail_count++;
            end
         end
      end
   end

   // Main sequence
   initial begin
      int waited;
      int ops_used;
      waited   = 0;
      ops_used = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_wrap_and_step();
      test_mul_div_corners();
      test_compare_equal();
      test_min_max_to_int();
      test_random_mix();
      start <= 1'b0;

      // drain the pipeline, then give stray words time to show up
      while (alu_answers_q.size() != 0 && waited < 4 * LATENCY) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 8) @(posedge clock);
      if (alu_answers_q.size() != 0) begin
         $error("%0d predicted result words never arrived", alu_answers_q.size());
         fail_count++;
      end

      foreach (op_hits[k]) if (op_hits[k] != 0) ops_used++;
      $display("Covered %0d command words over %0d of 16 opcodes, %0d result words seen,",
               words_sent, ops_used, words_seen);
      $display("%0d zero-divisor results, with idle gaps and back-to-back streaming.",
               zero_divs);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run (every word taking its longest idle gap).
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> fixed_point_alu_q24_8_unit.f
rtl/fxa_pkg.sv
rtl/fxa_front.sv
rtl/fxa_div_cell.sv
rtl/fixed_point_alu_q24_8_unit.sv
rtl/fxa_checker.sv
tb/tb_fixed_point_alu_q24_8_unit.sv
